// ----- hw/rtl/mbrx_pkg.sv -----
// ----------------------------------------------------------------------------
// mbrx_pkg
// Shared types, codes and the byte-wide CRC-16 update for the Modbus RTU
// frame receiver.
// ----------------------------------------------------------------------------
package mbrx_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned FLEN_W = 9;
  localparam int unsigned TICK_W = 4;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // function codes
  localparam logic [DATA_W-1:0] FC_READ_HOLDING = 8'h03;
  localparam logic [DATA_W-1:0] FC_WRITE_SINGLE = 8'h06;
  localparam logic [DATA_W-1:0] FC_WRITE_MULTI  = 8'h10;

  // register indexes (paddr bit 2)
  localparam logic REG_SLAVE_ID      = 1'b0;
  localparam logic REG_SILENCE_TICKS = 1'b1;

  localparam logic [DATA_W-1:0] SLAVE_ID_RST      = 8'h01;
  localparam logic [TICK_W-1:0] SILENCE_TICKS_RST = 4'd10;

  // input kinds and result kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_TICK   = 1'b1;
  localparam logic RK_PAYLOAD  = 1'b0;
  localparam logic RK_SUMMARY  = 1'b1;

  localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic [DATA_W-1:0] slave_id;
    logic [TICK_W-1:0] silence_ticks;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [DATA_W-1:0] function_code;
    logic [WORD_W-1:0] register_address;
    logic [WORD_W-1:0] value_or_quantity;
    logic [DATA_W-1:0] payload_byte;
    logic [FLEN_W-1:0] frame_length;
    logic              crc_ok;
  } res_t;

  // reflected CRC-16, one byte, LSB first
  function automatic logic [WORD_W-1:0] crc16_byte(input logic [WORD_W-1:0] crc,
                                                   input logic [DATA_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < DATA_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/mbrx_apb_regs.sv -----
// ----------------------------------------------------------------------------
// mbrx_apb_regs
// APB configuration registers: slave id and silence reload count.
// ----------------------------------------------------------------------------
module mbrx_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbrx_pkg::APB_AW-1:0]   paddr,
  input  logic [mbrx_pkg::APB_DW-1:0]   pwdata,
  output logic [mbrx_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output mbrx_pkg::cfg_t                cfg_o
);
  import mbrx_pkg::*;

  logic [DATA_W-1:0] slave_id_q;
  logic [TICK_W-1:0] silence_ticks_q;
  logic              wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_id_q      <= SLAVE_ID_RST;
      silence_ticks_q <= SILENCE_TICKS_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_SLAVE_ID:      slave_id_q      <= pwdata[DATA_W-1:0];
        REG_SILENCE_TICKS: silence_ticks_q <= pwdata[TICK_W-1:0];
        default:           slave_id_q      <= slave_id_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SLAVE_ID:      prdata = APB_DW'(slave_id_q);
      REG_SILENCE_TICKS: prdata = APB_DW'(silence_ticks_q);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.slave_id      = slave_id_q;
  assign cfg_o.silence_ticks = silence_ticks_q;

endmodule

// ----- hw/rtl/mbrx_frame.sv -----
// ----------------------------------------------------------------------------
// mbrx_frame
// Frame state and decode: byte counter, silence timer, held header fields,
// two-byte checksum window and running CRC. One beat per cycle while fire_i is high.
// ----------------------------------------------------------------------------
module mbrx_frame #(
  parameter int unsigned MAX_FRAME_BYTES = 256,
  parameter int unsigned CNT_W           = 9
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic                        kind_i,
  input  logic [mbrx_pkg::DATA_W-1:0] rx_byte_i,
  input  mbrx_pkg::cfg_t              cfg_i,
  output mbrx_pkg::res_t              res_o
);
  import mbrx_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FC  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_AHI = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_ALO = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_VHI = CNT_W'(4);
  localparam logic [CNT_W-1:0] CNT_VLO = CNT_W'(5);
  localparam logic [CNT_W-1:0] CNT_BC  = CNT_W'(6);
  localparam logic [CNT_W-1:0] CNT_FIX_END = CNT_W'(8);

  logic [CNT_W-1:0]  byte_count_q, byte_count_d;
  logic [TICK_W-1:0] silence_timer_q, silence_timer_d;
  logic [DATA_W-1:0] held_function_q, held_function_d;
  logic [WORD_W-1:0] held_address_q, held_address_d;
  logic [WORD_W-1:0] held_value_q, held_value_d;
  logic [DATA_W-1:0] payload_length_q, payload_length_d;
  logic [WORD_W-1:0] running_crc_q, running_crc_d;
  logic [WORD_W-1:0] last_two_q, last_two_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q     <= '0;
      silence_timer_q  <= '0;
      held_function_q  <= '0;
      held_address_q   <= '0;
      held_value_q     <= '0;
      payload_length_q <= '0;
      running_crc_q    <= CRC_INIT;
      last_two_q       <= '0;
    end else if (fire_i) begin
      byte_count_q     <= byte_count_d;
      silence_timer_q  <= silence_timer_d;
      held_function_q  <= held_function_d;
      held_address_q   <= held_address_d;
      held_value_q     <= held_value_d;
      payload_length_q <= payload_length_d;
      running_crc_q    <= running_crc_d;
      last_two_q       <= last_two_d;
    end
  end

  always_comb begin
    logic [CNT_W-1:0] cnt0;
    logic [CNT_W-1:0] cnt_inc;
    logic             quiet;
    logic             take;
    logic             done;
    logic             ok;
    logic [9:0]       multi_end;
    logic [9:0]       payload_end;

    byte_count_d     = byte_count_q;
    silence_timer_d  = silence_timer_q;
    held_function_d  = held_function_q;
    held_address_d   = held_address_q;
    held_value_d     = held_value_q;
    payload_length_d = payload_length_q;
    running_crc_d    = running_crc_q;
    last_two_d       = last_two_q;

    res_o                   = '0;
    res_o.function_code     = held_function_q;
    res_o.register_address  = held_address_q;
    res_o.value_or_quantity = held_value_q;

    quiet   = (silence_timer_q == '0);
    cnt0    = (quiet || byte_count_q == CNT_MAX) ? '0 : byte_count_q;
    cnt_inc = cnt0 + CNT_ONE;
    take    = 1'b0;
    done    = 1'b0;
    ok      = 1'b0;
    payload_end = 10'(payload_length_q) + 10'd7;
    multi_end   = 10'(payload_length_q) + 10'd9;

    if (kind_i == KIND_TICK) begin
      if (!quiet) begin
        silence_timer_d = silence_timer_q - TICK_W'(1);
      end
    end else begin
      byte_count_d = cnt0;
      if (quiet && rx_byte_i == cfg_i.slave_id) begin
        running_crc_d    = CRC_INIT;
        last_two_d       = {8'h00, rx_byte_i};
        payload_length_d = '0;
        byte_count_d     = CNT_ONE;
      end else if (cnt0 == CNT_FC && (rx_byte_i == FC_READ_HOLDING ||
                   rx_byte_i == FC_WRITE_SINGLE || rx_byte_i == FC_WRITE_MULTI)) begin
        held_function_d = rx_byte_i;
        take            = 1'b1;
      end else if (cnt0 >= CNT_AHI && cnt0 <= CNT_VLO) begin
        case (cnt0)
          CNT_AHI: held_address_d[15:8] = rx_byte_i;
          CNT_ALO: held_address_d[7:0]  = rx_byte_i;
          CNT_VHI: held_value_d[15:8]   = rx_byte_i;
          default: held_value_d[7:0]    = rx_byte_i;
        endcase
        take = 1'b1;
      end else if (cnt0 >= CNT_BC && (held_function_q == FC_READ_HOLDING ||
                   held_function_q == FC_WRITE_SINGLE)) begin
        take = 1'b1;
        done = (cnt_inc == CNT_FIX_END);
      end else if (cnt0 >= CNT_BC && held_function_q == FC_WRITE_MULTI) begin
        if (cnt0 == CNT_BC) begin
          payload_length_d = rx_byte_i;
        end else if (10'(cnt0) < payload_end) begin
          res_o.valid        = 1'b1;
          res_o.kind         = RK_PAYLOAD;
          res_o.payload_byte = rx_byte_i;
        end
        take = 1'b1;
        // byte count opens no frame end, so the old length is safe here
        done = (10'(cnt_inc) == multi_end) && (cnt0 != CNT_BC);
      end else begin
        byte_count_d = '0;
      end

      if (take) begin
        // the byte leaving the checksum window enters the CRC
        if (cnt0 >= CNT_AHI) begin
          running_crc_d = crc16_byte(running_crc_q, last_two_q[15:8]);
        end
        last_two_d   = {last_two_q[7:0], rx_byte_i};
        byte_count_d = cnt_inc;
      end

      silence_timer_d = cfg_i.silence_ticks;

      if (done) begin
        ok                 = (running_crc_d == last_two_d);
        res_o.valid        = 1'b1;
        res_o.kind         = RK_SUMMARY;
        res_o.payload_byte = '0;
        res_o.frame_length = FLEN_W'(cnt_inc);
        res_o.crc_ok       = ok;
        byte_count_d       = '0;
        if (ok) begin
          silence_timer_d = '0;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/modbus_rtu_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver_core
// Modbus RTU slave frame receiver: address/function filter, header capture,
// multi-write payload stream and CRC-16 check at frame end.
// ----------------------------------------------------------------------------
// Path: an accepted input beat passes through the input register, then decode
// and CRC update into the result register, which drives the output.
// Throughput: one input beat per cycle; the byte-wide CRC update sits in the
// decode stage. Stall only builds up when the output is stalled with a result.
// Reset: asynchronous, active low; clears both pipeline valids and frame
// state, config returns to slave id 1 and 10 silence ticks.
module modbus_rtu_frame_receiver_core #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [mbrx_pkg::DATA_W-1:0]   rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          result_kind_o,
  output logic [mbrx_pkg::DATA_W-1:0]   function_code_o,
  output logic [mbrx_pkg::WORD_W-1:0]   register_address_o,
  output logic [mbrx_pkg::WORD_W-1:0]   value_or_quantity_o,
  output logic [mbrx_pkg::DATA_W-1:0]   payload_byte_o,
  output logic [mbrx_pkg::FLEN_W-1:0]   frame_length_o,
  output logic                          crc_ok_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbrx_pkg::APB_AW-1:0]   paddr,
  input  logic [mbrx_pkg::APB_DW-1:0]   pwdata,
  output logic [mbrx_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import mbrx_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  cfg_t              cfg;
  res_t              res;
  logic              in_valid_q;
  logic              kind_q;
  logic [DATA_W-1:0] rx_byte_q;
  logic              advance;
  logic              fire;
  res_t              out_q;
  logic              out_valid_q;

  mbrx_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      kind_q    <= kind_i;
      rx_byte_q <= rx_byte_i;
    end
  end

  mbrx_frame #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .CNT_W           (CNT_W)
  ) u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .kind_i    (kind_q),
    .rx_byte_i (rx_byte_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign result_kind_o       = out_q.kind;
  assign function_code_o     = out_q.function_code;
  assign register_address_o  = out_q.register_address;
  assign value_or_quantity_o = out_q.value_or_quantity;
  assign payload_byte_o      = out_q.payload_byte;
  assign frame_length_o      = out_q.frame_length;
  assign crc_ok_o            = out_q.crc_ok;

endmodule

// ----- hw/rtl/mbrx_checker.sv -----
// ----------------------------------------------------------------------------
// mbrx_checker
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module mbrx_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          result_kind_o,
  input logic [mbrx_pkg::DATA_W-1:0]   function_code_o,
  input logic [mbrx_pkg::DATA_W-1:0]   payload_byte_o,
  input logic [mbrx_pkg::FLEN_W-1:0]   frame_length_o,
  input logic                          crc_ok_o,
  input logic                          pready
);
  import mbrx_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(payload_byte_o) &&
    $stable(frame_length_o) && $stable(result_kind_o))
    else $error("stalled result beat changed");

  a_payload_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == RK_PAYLOAD |->
    frame_length_o == '0 && !crc_ok_o && function_code_o == FC_WRITE_MULTI)
    else $error("payload beat carries summary fields");

  a_summary_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == RK_SUMMARY |->
    payload_byte_o == '0 && frame_length_o >= FLEN_W'(8))
    else $error("summary beat malformed");

  a_summary_fc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> function_code_o == FC_READ_HOLDING ||
    function_code_o == FC_WRITE_SINGLE || function_code_o == FC_WRITE_MULTI)
    else $error("result beat with unsupported function code");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind modbus_rtu_frame_receiver_core mbrx_checker u_mbrx_checker (.*);

// ----- tb/modbus_rtu_frame_receiver_core_test.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver_core_test
// Self-checking bench for the Modbus RTU frame receiver. A short table of
// directed beats comes first. Random frames, noise and tick streams follow
// under several slave id / silence settings. Every result beat is compared
// against an in-bench tracker of the frame state and CRC. Both handshakes
// idle at random.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_receiver_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbrx_pkg::*;

  localparam int unsigned FRAME_CAP      = 256;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          RESET_CYCLES   = 12;
  localparam int          PHASE_BEATS    = 40;
  localparam int          N_PHASES       = 6;

  localparam logic [APB_AW-1:0] ADDR_SLAVE_ID = {REG_SLAVE_ID, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_SILENCE  = {REG_SILENCE_TICKS, 2'b00};

  // directed rows: either "no result here" is typed in, or the tracker decides
  localparam logic CHK_MODEL = 1'b0;
  localparam logic CHK_NONE  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] data;
    logic              check;
  } dir_row_t;

  typedef struct packed {
    logic              rkind;
    logic [DATA_W-1:0] func;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] value;
    logic [DATA_W-1:0] pbyte;
    logic [FLEN_W-1:0] flen;
    logic              crc_ok;
  } frame_event_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic              kind_i      = KIND_TICK;
  logic [DATA_W-1:0] rx_byte_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              result_kind_o;
  logic [DATA_W-1:0] function_code_o;
  logic [WORD_W-1:0] register_address_o;
  logic [WORD_W-1:0] value_or_quantity_o;
  logic [DATA_W-1:0] payload_byte_o;
  logic [FLEN_W-1:0] frame_length_o;
  logic              crc_ok_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  modbus_rtu_frame_receiver_core #(
    .MAX_FRAME_BYTES(FRAME_CAP)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind_i),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .result_kind_o      (result_kind_o),
    .function_code_o    (function_code_o),
    .register_address_o (register_address_o),
    .value_or_quantity_o(value_or_quantity_o),
    .payload_byte_o     (payload_byte_o),
    .frame_length_o     (frame_length_o),
    .crc_ok_o           (crc_ok_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #2 clk_i = ~clk_i;

  // tracker copy of the block's registers and frame state
  logic [DATA_W-1:0] cfg_sid   = SLAVE_ID_RST;
  logic [TICK_W-1:0] cfg_ticks = SILENCE_TICKS_RST;
  int                byte_idx  = 0;
  logic [TICK_W-1:0] quiet_timer = '0;
  logic [DATA_W-1:0] cur_func  = '0;
  logic [WORD_W-1:0] cur_addr  = '0;
  logic [WORD_W-1:0] cur_value = '0;
  logic [DATA_W-1:0] pay_count = '0;
  logic [WORD_W-1:0] crc_acc   = 16'hFFFF;
  logic [WORD_W-1:0] crc_tail  = '0;

  frame_event_t frame_events_due[$];

  int  errors      = 0;
  int  beats_in    = 0;
  int  frame_beats = 0;
  int  n_payload   = 0;
  int  n_summary   = 0;
  int  n_crc_bad   = 0;
  int  n_settings  = 0;
  int  stall_left  = 0;
  int  idle_cycles = 0;
  bit  steady      = 1'b0;

  // slave id 1, one silence tick (written before the table runs)
  dir_row_t dir_rows [26] = '{
    '{KIND_TICK, 8'h00, CHK_NONE},   // tick on a quiet line
    '{KIND_BYTE, 8'h01, CHK_MODEL},  // read holding, addr 0, qty 1
    '{KIND_BYTE, 8'h03, CHK_MODEL},
    '{KIND_BYTE, 8'h00, CHK_MODEL},
    '{KIND_BYTE, 8'h00, CHK_MODEL},
    '{KIND_BYTE, 8'h00, CHK_MODEL},
    '{KIND_BYTE, 8'h01, CHK_MODEL},
    '{KIND_BYTE, 8'h0A, CHK_MODEL},
    '{KIND_BYTE, 8'h84, CHK_MODEL},
    '{KIND_BYTE, 8'hFF, CHK_NONE},   // foreign address on quiet line
    '{KIND_BYTE, 8'h01, CHK_NONE},   // own address, line not quiet
    '{KIND_TICK, 8'hFF, CHK_NONE},
    '{KIND_BYTE, 8'h01, CHK_MODEL},
    '{KIND_BYTE, 8'h07, CHK_NONE},   // unsupported function
    '{KIND_TICK, 8'h00, CHK_NONE},
    '{KIND_BYTE, 8'h01, CHK_MODEL},  // multi-write, addr FFFF, two bytes
    '{KIND_BYTE, 8'h10, CHK_MODEL},
    '{KIND_BYTE, 8'hFF, CHK_MODEL},
    '{KIND_BYTE, 8'hFF, CHK_MODEL},
    '{KIND_BYTE, 8'h00, CHK_MODEL},
    '{KIND_BYTE, 8'h01, CHK_MODEL},
    '{KIND_BYTE, 8'h02, CHK_MODEL},
    '{KIND_BYTE, 8'h00, CHK_MODEL},
    '{KIND_BYTE, 8'hFF, CHK_MODEL},
    '{KIND_BYTE, 8'h5A, CHK_MODEL},
    '{KIND_BYTE, 8'hC3, CHK_MODEL}
  };

  // reflected CRC-16, bit serial with the data bit folded into the feedback
  function automatic logic [WORD_W-1:0] crc16_step(input logic [WORD_W-1:0] acc,
                                                   input logic [DATA_W-1:0] d);
    logic [WORD_W-1:0] r;
    r = acc;
    for (int i = 0; i < DATA_W; i++) begin
      r = (r[0] ^ d[i]) ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    end
    return r;
  endfunction

  task automatic push_event(input logic rk, input logic [DATA_W-1:0] pb,
                            input logic [FLEN_W-1:0] fl, input logic ok);
    frame_event_t ev;
    ev.rkind  = rk;
    ev.func   = cur_func;
    ev.addr   = cur_addr;
    ev.value  = cur_value;
    ev.pbyte  = pb;
    ev.flen   = fl;
    ev.crc_ok = ok;
    frame_events_due.push_back(ev);
  endtask

  // two newest bytes wait in the tail; the one pushed out enters the CRC
  task automatic shift_in(input logic [DATA_W-1:0] b);
    if (byte_idx >= 2) crc_acc = crc16_step(crc_acc, crc_tail[15:8]);
    crc_tail = {crc_tail[7:0], b};
  endtask

  task automatic track_rx_beat(input logic k, input logic [DATA_W-1:0] b,
                               input bit record);
    bit   done;
    logic ok;
    done = 1'b0;
    if (k == KIND_TICK) begin
      if (quiet_timer > 0) quiet_timer = quiet_timer - TICK_W'(1);
      return;
    end
    if (quiet_timer == 0) byte_idx = 0;
    if (byte_idx >= FRAME_CAP) byte_idx = 0;
    if (quiet_timer == 0 && b == cfg_sid) begin
      crc_acc   = 16'hFFFF;
      crc_tail  = {8'h00, b};
      pay_count = '0;
      byte_idx  = 1;
    end else if (byte_idx == 1 && (b == FC_READ_HOLDING || b == FC_WRITE_SINGLE ||
                                   b == FC_WRITE_MULTI)) begin
      cur_func = b;
      shift_in(b);
      byte_idx = 2;
    end else if (byte_idx >= 2 && byte_idx <= 5) begin
      case (byte_idx)
        2:       cur_addr[15:8]  = b;
        3:       cur_addr[7:0]   = b;
        4:       cur_value[15:8] = b;
        default: cur_value[7:0]  = b;
      endcase
      shift_in(b);
      byte_idx++;
    end else if (byte_idx >= 6 && (cur_func == FC_READ_HOLDING ||
                                   cur_func == FC_WRITE_SINGLE)) begin
      shift_in(b);
      byte_idx++;
      if (byte_idx == 8) done = 1'b1;
    end else if (byte_idx >= 6 && cur_func == FC_WRITE_MULTI) begin
      if (byte_idx == 6) begin
        pay_count = b;
      end else if (byte_idx < 7 + int'(pay_count)) begin
        if (record) push_event(RK_PAYLOAD, b, '0, 1'b0);
      end
      shift_in(b);
      byte_idx++;
      if (byte_idx == 9 + int'(pay_count)) done = 1'b1;
    end else begin
      byte_idx = 0;
    end
    quiet_timer = cfg_ticks;
    if (done || byte_idx != 0) frame_beats++;
    if (done) begin
      ok = (crc_acc == crc_tail);
      if (record) push_event(RK_SUMMARY, '0, FLEN_W'(byte_idx), ok);
      byte_idx = 0;
      if (ok) quiet_timer = '0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_beat(input logic k, input logic [DATA_W-1:0] d, input bit typed_none);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    rx_byte_i  <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_in++;
    track_rx_beat(k, d, !typed_none);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frame_events_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_AW-1:0] a,
                            input logic [APB_DW-1:0] d, output logic [APB_DW-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [DATA_W-1:0] sid, input logic [TICK_W-1:0] ticks);
    logic [APB_DW-1:0] unused;
    apb_access(1'b1, ADDR_SLAVE_ID, APB_DW'(sid), unused);
    apb_access(1'b1, ADDR_SILENCE, APB_DW'(ticks), unused);
    cfg_sid   = sid;
    cfg_ticks = ticks;
    n_settings++;
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return WORD_W'($urandom);
  endfunction

  function automatic logic [DATA_W-1:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return FC_READ_HOLDING;
    if (r < 60) return FC_WRITE_SINGLE;
    if (r < 95) return FC_WRITE_MULTI;
    return DATA_W'($urandom);
  endfunction

  // clean frames: right address, enough quiet, good CRC, nothing cut or inserted
  task automatic send_frame(input logic [DATA_W-1:0] fc, input int n_pay, input bit clean);
    logic [DATA_W-1:0] frm[$];
    logic [WORD_W-1:0] crc;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] val;
    logic [DATA_W-1:0] sid;
    int                pre;
    int                cut;
    addr = pick_word();
    val  = pick_word();
    sid  = (!clean && $urandom_range(0, 15) == 0) ? DATA_W'($urandom) : cfg_sid;
    if (clean) pre = int'(cfg_ticks);
    else if ($urandom_range(0, 7) == 0) pre = 0;
    else if ($urandom_range(0, 9) == 0) pre = $urandom_range(0, int'(cfg_ticks));
    else pre = int'(cfg_ticks) + $urandom_range(0, 2);
    repeat (pre) send_beat(KIND_TICK, DATA_W'($urandom), 1'b0);
    frm = '{sid, fc, addr[15:8], addr[7:0], val[15:8], val[7:0]};
    if (fc == FC_WRITE_MULTI) begin
      frm.push_back(DATA_W'(n_pay));
      repeat (n_pay) frm.push_back(DATA_W'($urandom));
    end
    crc = 16'hFFFF;
    foreach (frm[i]) crc = crc16_step(crc, frm[i]);
    frm.push_back(crc[15:8]);
    frm.push_back(crc[7:0]);
    if (!clean && $urandom_range(0, 99) < 15)
      frm[frm.size() - 1 - $urandom_range(0, 1)] ^= 8'h01 << $urandom_range(0, 7);
    cut = (!clean && $urandom_range(0, 19) == 0) ? $urandom_range(1, frm.size() - 1)
                                                 : frm.size();
    for (int j = 0; j < cut; j++) begin
      if (!clean && $urandom_range(0, 29) == 0)
        send_beat(KIND_TICK, DATA_W'($urandom), 1'b0);
      send_beat(KIND_BYTE, frm[j], 1'b0);
    end
  endtask

  task automatic send_noise();
    int r;
    repeat ($urandom_range(1, 6)) begin
      r = $urandom_range(0, 2);
      if (r == 0) send_beat(KIND_TICK, DATA_W'($urandom), 1'b0);
      else if (r == 1) send_beat(KIND_BYTE, DATA_W'($urandom), 1'b0);
      else send_beat(KIND_BYTE, cfg_sid, 1'b0);
    end
  endtask

  task automatic cmp(input string name, input logic [WORD_W-1:0] want,
                     input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    frame_event_t want;
    if (frame_events_due.size() == 0) begin
      $error("result beat with nothing pending: kind %0b fc %h len %0d",
             result_kind_o, function_code_o, frame_length_o);
      errors++;
      return;
    end
    want = frame_events_due.pop_front();
    cmp("result_kind", WORD_W'(want.rkind), WORD_W'(result_kind_o));
    cmp("function_code", WORD_W'(want.func), WORD_W'(function_code_o));
    cmp("register_address", want.addr, register_address_o);
    cmp("value_or_quantity", want.value, value_or_quantity_o);
    cmp("payload_byte", WORD_W'(want.pbyte), WORD_W'(payload_byte_o));
    cmp("frame_length", WORD_W'(want.flen), WORD_W'(frame_length_o));
    cmp("crc_ok", WORD_W'(want.crc_ok), WORD_W'(crc_ok_o));
    if (want.rkind == RK_PAYLOAD) n_payload++;
    else n_summary++;
    if (want.rkind == RK_SUMMARY && !want.crc_ok) n_crc_bad++;
  endtask

  // result side: check accepted beats, then pick next cycle's stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result();
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (steady || $urandom_range(0, 99) < 70) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b1;
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [APB_DW-1:0] rd;
    logic [DATA_W-1:0] sids  [N_PHASES];
    logic [TICK_W-1:0] ticks [N_PHASES];
    int                tries;
    int                cap;

    sids  = '{8'h01, 8'h00, 8'hFF, DATA_W'($urandom), 8'h5A, DATA_W'($urandom)};
    ticks = '{4'd10, 4'd15, 4'd1, TICK_W'($urandom_range(1, 15)), 4'd0,
              TICK_W'($urandom_range(1, 15))};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_access(1'b0, ADDR_SLAVE_ID, '0, rd);
    cmp("slave_id after reset", WORD_W'(SLAVE_ID_RST), WORD_W'(rd[DATA_W-1:0]));
    apb_access(1'b0, ADDR_SILENCE, '0, rd);
    cmp("silence_ticks after reset", WORD_W'(SILENCE_TICKS_RST), WORD_W'(rd[TICK_W-1:0]));

    set_config(SLAVE_ID_RST, 4'd1);
    foreach (dir_rows[i]) send_beat(dir_rows[i].kind, dir_rows[i].data,
                                    dir_rows[i].check == CHK_NONE);

    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      set_config(sids[p], ticks[p]);
      steady = (p == 1);
      if (p == 2) begin
        // longest frame that still ends, then one that overruns the cap
        send_frame(FC_WRITE_MULTI, FRAME_CAP - 9, 1'b1);
        send_frame(FC_WRITE_MULTI, 255, 1'b1);
      end
      frame_beats = 0;
      tries = 0;
      cap = (ticks[p] == 0) ? 10 : 4000;
      while (frame_beats < PHASE_BEATS && tries < cap) begin
        tries++;
        if ($urandom_range(0, 3) == 0) send_noise();
        else send_frame(pick_func(),
                        ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                    : $urandom_range(0, 6), 1'b0);
        // sender holds off until the result side is empty
        if ($urandom_range(0, 29) == 0) wait_drained();
      end
    end
    steady = 1'b0;
    wait_drained();

    $display("Ran %0d input beats over %0d register settings, incl. quiet-line, bad-function,",
             beats_in, n_settings);
    $display("overlong and full-size frames: %0d payload and %0d summary beats (%0d bad CRC).",
             n_payload, n_summary, n_crc_bad);
    if (errors == 0 && frame_events_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/mbrx_pkg.sv
hw/rtl/mbrx_apb_regs.sv
hw/rtl/mbrx_frame.sv
hw/rtl/modbus_rtu_frame_receiver_core.sv
hw/rtl/mbrx_checker.sv
tb/modbus_rtu_frame_receiver_core_test.sv
